// ===== hw/rtl/ps2mct_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ps2mct_pkg;

  // screen size register and axis widths
  localparam int unsigned SIZE_W   = 13;
  localparam int unsigned AXIS_W   = 12;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned BTN_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = SIZE_W;

  // reset values
  localparam logic [SIZE_W-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [SIZE_W-1:0] RESET_HEIGHT = 13'd480;
  localparam logic [AXIS_W-1:0] AXIS_MAX     = 12'd4095;

  // first byte of a packet always carries this bit
  localparam int unsigned SYNC_BIT = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1
  } cfg_reg_t;

  // packet byte position
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_XDELTA = 2'd1,
    PH_YDELTA = 2'd2
  } phase_t;

  // one registered controller byte
  typedef struct packed {
    logic              aux;
    logic [BYTE_W-1:0] data;
  } item_t;

  // largest coordinate for a screen size: size-1, saturated to the 12-bit range
  function automatic logic [AXIS_W-1:0] axis_limit(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] lim;
    begin
      lim = (size == '0) ? '0 : size - 1'b1;
      axis_limit = (lim > {1'b0, AXIS_MAX}) ? AXIS_MAX : lim[AXIS_W-1:0];
    end
  endfunction

  // center of an axis; size/2 never exceeds the limit
  function automatic logic [AXIS_W-1:0] axis_center(input logic [SIZE_W-1:0] size);
    axis_center = size[SIZE_W-1:1];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ps2_mouse_cursor_tracker_top.sv =====
// PS/2 mouse cursor tracker
//
// Input channel (in_valid / in_stall): one controller byte per transfer with
// in_aux_data set when it came from the mouse. Bytes from the keyboard side
// are dropped. Three-byte packets are framed, resyncing on bit 3 of byte one.
// Output channel (out_valid / out_stall): one transfer per complete packet
// with the clamped cursor position and the left/right/middle button bits.
// Config channel (cfg_valid / cfg_ready): index 0 screen width, index 1
// screen height; cfg_ready is always high. Any size write recenters the cursor.
// Write configuration only while no packet is in flight.
//
// Throughput: one byte per cycle while in_stall is low. Path: a third byte
// is registered in the input register, the add/clamp logic then loads the
// result register, which raises out_valid, and the result transfers once
// out_stall is low.
// Reset (rst_n low, synchronous): 640x480 screen, cursor at (320,240), packet
// framing waits for a first byte, output empty.
// A stalled result holds in the result register; one more byte waits in the
// input register, after which in_stall rises until the result transfers.
`timescale 1ns / 1ps
`default_nettype none

module ps2_mouse_cursor_tracker_top (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire                                in_aux_data,
  input  wire  [ps2mct_pkg::BYTE_W-1:0]      in_data_byte,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [ps2mct_pkg::AXIS_W-1:0]      out_cursor_x,
  output logic [ps2mct_pkg::AXIS_W-1:0]      out_cursor_y,
  output logic [ps2mct_pkg::BTN_W-1:0]       out_buttons,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [ps2mct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [ps2mct_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import ps2mct_pkg::*;

  logic  item_valid;
  item_t item;
  logic  adv;

  assign cfg_ready = 1'b1;

  // input register stage
  ps2mct_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_aux_data  (in_aux_data),
    .in_data_byte (in_data_byte),
    .adv          (adv),
    .item_valid   (item_valid),
    .item         (item)
  );

  // packet framing, cursor update and result register
  ps2mct_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item         (item),
    .adv          (adv),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_idx      (cfg_index),
    .cfg_dat      (cfg_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_cursor_x (out_cursor_x),
    .out_cursor_y (out_cursor_y),
    .out_buttons  (out_buttons)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/ps2mct_in_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ps2mct_in_reg (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire                              in_aux_data,
  input  wire  [ps2mct_pkg::BYTE_W-1:0]    in_data_byte,
  input  wire                              adv,
  output logic                             item_valid,
  output ps2mct_pkg::item_t                item
);
  import ps2mct_pkg::*;

  logic  item_valid_r;
  item_t item_r;

  // hold the byte while the core cannot take it
  assign in_stall   = item_valid_r && !adv;
  assign item_valid = item_valid_r;
  assign item       = item_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (!in_stall) begin
      item_valid_r <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r.aux  <= in_aux_data;
      item_r.data <= in_data_byte;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ps2mct_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ps2mct_core (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                item_valid,
  input  ps2mct_pkg::item_t                  item,
  output logic                               adv,
  input  wire                                cfg_we,
  input  wire  [ps2mct_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire  [ps2mct_pkg::CFG_DAT_W-1:0]   cfg_dat,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [ps2mct_pkg::AXIS_W-1:0]      out_cursor_x,
  output logic [ps2mct_pkg::AXIS_W-1:0]      out_cursor_y,
  output logic [ps2mct_pkg::BTN_W-1:0]       out_buttons
);
  import ps2mct_pkg::*;

  localparam int unsigned SUM_W = AXIS_W + 2;

  phase_t              phase_r, phase_nxt;
  logic [SIZE_W-1:0]   width_r, height_r;
  logic [AXIS_W-1:0]   pos_x_r, pos_y_r;
  logic [BTN_W-1:0]    btn_r;
  logic [BYTE_W-1:0]   xdelta_r;
  logic                out_valid_r;
  logic [AXIS_W-1:0]   out_x_r, out_y_r;
  logic [BTN_W-1:0]    out_btn_r;

  logic                proc;
  logic                emit;
  logic                cap_first;
  logic                cap_x;
  logic [SIZE_W-1:0]   width_nxt, height_nxt;
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic [AXIS_W-1:0]   lim_x, lim_y, new_x, new_y;

  // the result register frees up when empty or when its transfer completes
  assign adv  = !out_valid_r || !out_stall;
  assign proc = item_valid && adv && item.aux;

  // next packet position
  always_comb begin
    phase_nxt = phase_r;
    if (proc) begin
      case (phase_r)
        PH_FIRST:  phase_nxt = item.data[SYNC_BIT] ? PH_XDELTA : PH_FIRST;
        PH_XDELTA: phase_nxt = PH_YDELTA;
        PH_YDELTA: phase_nxt = PH_FIRST;
        default:   phase_nxt = PH_FIRST;
      endcase
    end
  end

  // per-phase actions
  always_comb begin
    cap_first = 1'b0;
    cap_x     = 1'b0;
    emit      = 1'b0;
    if (proc) begin
      case (phase_r)
        PH_FIRST:  cap_first = item.data[SYNC_BIT];
        PH_XDELTA: cap_x     = 1'b1;
        PH_YDELTA: emit      = 1'b1;
        default:   ;
      endcase
    end
  end

  // move and clamp: x adds its delta, y subtracts (screen down is positive)
  always_comb begin
    lim_x = axis_limit(width_r);
    lim_y = axis_limit(height_r);
    sum_x = $signed({2'b00, pos_x_r}) + SUM_W'($signed(xdelta_r));
    sum_y = $signed({2'b00, pos_y_r}) - SUM_W'($signed(item.data));
    if (sum_x < 0) begin
      new_x = '0;
    end else if (sum_x[SUM_W-2:0] > {1'b0, lim_x}) begin
      new_x = lim_x;
    end else begin
      new_x = sum_x[AXIS_W-1:0];
    end
    if (sum_y < 0) begin
      new_y = '0;
    end else if (sum_y[SUM_W-2:0] > {1'b0, lim_y}) begin
      new_y = lim_y;
    end else begin
      new_y = sum_y[AXIS_W-1:0];
    end
  end

  // screen size after a register write
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      case (cfg_idx)
        REG_SCREEN_WIDTH:  width_nxt  = cfg_dat;
        REG_SCREEN_HEIGHT: height_nxt = cfg_dat;
        default:           ;
      endcase
    end
  end

  // control and cursor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FIRST;
      width_r     <= RESET_WIDTH;
      height_r    <= RESET_HEIGHT;
      pos_x_r     <= axis_center(RESET_WIDTH);
      pos_y_r     <= axis_center(RESET_HEIGHT);
      btn_r       <= '0;
      xdelta_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      if (cfg_we && (cfg_idx == REG_SCREEN_WIDTH || cfg_idx == REG_SCREEN_HEIGHT)) begin
        // a size write recenters the cursor
        pos_x_r <= axis_center(width_nxt);
        pos_y_r <= axis_center(height_nxt);
      end else if (emit) begin
        pos_x_r <= new_x;
        pos_y_r <= new_y;
      end
      if (cap_first) begin
        btn_r <= item.data[BTN_W-1:0];
      end
      if (cap_x) begin
        xdelta_r <= item.data;
      end
      if (adv) begin
        out_valid_r <= emit;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_x_r   <= new_x;
      out_y_r   <= new_y;
      out_btn_r <= btn_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_cursor_x = out_x_r;
  assign out_cursor_y = out_y_r;
  assign out_buttons  = out_btn_r;

endmodule

`default_nettype wire

// ===== tb/tb_ps2_mouse_cursor_tracker_top.sv =====
`timescale 1ns / 1ps

module tb_ps2_mouse_cursor_tracker_top;
  import ps2mct_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned RAND_PHASES = 8;
  localparam int unsigned BYTES_PER_PHASE = 224;
  localparam int unsigned DIR_ROWS = 27;

  // register indexes past the end of the list, writes must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [AXIS_W-1:0] x;
    logic [AXIS_W-1:0] y;
    logic [BTN_W-1:0]  btn;
  } cursor_t;

  typedef enum logic {
    ROW_BYTE,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic               aux;
    logic [BYTE_W-1:0]  b;
    logic [CFG_IDX_W-1:0] idx;
    logic [SIZE_W-1:0]  val;
    logic               typed;
    cursor_t            want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_aux_data = 1'b0;
  logic [BYTE_W-1:0] in_data_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [AXIS_W-1:0] out_cursor_x;
  logic [AXIS_W-1:0] out_cursor_y;
  logic [BTN_W-1:0] out_buttons;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // tracker shadow state
  logic [SIZE_W-1:0] scr_w = RESET_WIDTH;
  logic [SIZE_W-1:0] scr_h = RESET_HEIGHT;
  phase_t pkt_phase = PH_FIRST;
  logic [BYTE_W-1:0] pkt_first = '0;
  logic [BYTE_W-1:0] pkt_dx = '0;
  int unsigned cur_x = 320;
  int unsigned cur_y = 240;

  cursor_t expected_cursor_q[$];
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned calm_left = 0;

  // directed packets: defaults, dropped bytes, clamps at tiny and huge screens
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_BYTE, 1'b1, 8'h08, REG_SCREEN_WIDTH, 13'd0, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{ROW_BYTE, 1'b1, 8'h00, REG_SCREEN_WIDTH, 13'd0, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{ROW_BYTE, 1'b1, 8'h00, REG_SCREEN_WIDTH, 13'd0, 1'b1, '{12'd320, 12'd240, 3'd0}},
    '{ROW_BYTE, 1'b0, 8'hFF, REG_SCREEN_WIDTH, 13'd0, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{ROW_BYTE, 1'b1, 8'hF7, REG_SCREEN_WIDTH, 13'd0, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{ROW_BYTE, 1'b1, 8'h0F, REG_SCREEN_WIDTH, 13'd0, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{ROW_BYTE, 1'b0, 8'h08, REG_SCREEN_WIDTH, 13'd0, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{ROW_BYTE, 1'b1, 8'h7F, REG_SCREEN_WIDTH, 13'd0, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{ROW_BYTE, 1'b1, 8'h80, REG_SCREEN_WIDTH, 13'd0, 1'b1, '{12'd447, 12'd368, 3'd7}},
    '{ROW_BYTE, 1'b1, 8'h0B, REG_SCREEN_WIDTH, 13'd0, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{ROW_BYTE, 1'b1, 8'h80, REG_SCREEN_WIDTH, 13'd0, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{ROW_BYTE, 1'b1, 8'h7F, REG_SCREEN_WIDTH, 13'd0, 1'b1, '{12'd319, 12'd241, 3'd3}},
    '{ROW_CFG, 1'b0, 8'h00, REG_SCREEN_WIDTH, 13'd1, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{ROW_CFG, 1'b0, 8'h00, REG_SCREEN_HEIGHT, 13'd0, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{ROW_BYTE, 1'b1, 8'h0C, REG_SCREEN_WIDTH, 13'd0, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{ROW_BYTE, 1'b1, 8'h7F, REG_SCREEN_WIDTH, 13'd0, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{ROW_BYTE, 1'b1, 8'h80, REG_SCREEN_WIDTH, 13'd0, 1'b1, '{12'd0, 12'd0, 3'd4}},
    '{ROW_CFG, 1'b0, 8'h00, REG_SCREEN_WIDTH, 13'd8191, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{ROW_CFG, 1'b0, 8'h00, REG_SCREEN_HEIGHT, 13'd4096, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{ROW_CFG, 1'b0, 8'h00, REG_SPARE_2, 13'h1555, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{ROW_CFG, 1'b0, 8'h00, REG_SPARE_3, 13'h0AAA, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{ROW_BYTE, 1'b1, 8'hF8, REG_SCREEN_WIDTH, 13'd0, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{ROW_BYTE, 1'b1, 8'h01, REG_SCREEN_WIDTH, 13'd0, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{ROW_BYTE, 1'b1, 8'h80, REG_SCREEN_WIDTH, 13'd0, 1'b1, '{12'd4095, 12'd2176, 3'd0}},
    '{ROW_BYTE, 1'b1, 8'hFF, REG_SCREEN_WIDTH, 13'd0, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{ROW_BYTE, 1'b1, 8'hFF, REG_SCREEN_WIDTH, 13'd0, 1'b0, '{12'd0, 12'd0, 3'd0}},
    '{ROW_BYTE, 1'b1, 8'h7F, REG_SCREEN_WIDTH, 13'd0, 1'b0, '{12'd0, 12'd0, 3'd0}}
  };

  ps2_mouse_cursor_tracker_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_aux_data  (in_aux_data),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_cursor_x (out_cursor_x),
    .out_cursor_y (out_cursor_y),
    .out_buttons  (out_buttons),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // largest coordinate on an axis of the given size
  function automatic int unsigned size_limit(input logic [SIZE_W-1:0] sz);
    int unsigned lim;
    lim = (sz == '0) ? 0 : int'(sz) - 1;
    return (lim > int'(AXIS_MAX)) ? int'(AXIS_MAX) : lim;
  endfunction

  function automatic int unsigned size_center(input logic [SIZE_W-1:0] sz);
    int unsigned c;
    c = int'(sz) / 2;
    return (c > size_limit(sz)) ? size_limit(sz) : c;
  endfunction

  function automatic int unsigned clamp_to_screen(input int v, input logic [SIZE_W-1:0] sz);
    if (v < 0) return 0;
    if (v > int'(size_limit(sz))) return size_limit(sz);
    return v;
  endfunction

  // shadow of a size register write, any real register recenters
  function automatic void apply_size_write(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [SIZE_W-1:0] val);
    if (idx == REG_SCREEN_WIDTH) begin
      scr_w = val;
    end else if (idx == REG_SCREEN_HEIGHT) begin
      scr_h = val;
    end else begin
      return;
    end
    cur_x = size_center(scr_w);
    cur_y = size_center(scr_h);
  endfunction

  // packet framing and cursor motion for one accepted byte
  function automatic void track_mouse_byte(input logic aux, input logic [BYTE_W-1:0] b,
                                           output logic hit, output cursor_t res);
    int nx;
    int ny;
    hit = 1'b0;
    res = '0;
    if (!aux) return;
    case (pkt_phase)
      PH_XDELTA: begin
        pkt_dx = b;
        pkt_phase = PH_YDELTA;
      end
      PH_YDELTA: begin
        nx = int'(cur_x) + int'($signed(pkt_dx));
        ny = int'(cur_y) - int'($signed(b));
        cur_x = clamp_to_screen(nx, scr_w);
        cur_y = clamp_to_screen(ny, scr_h);
        pkt_phase = PH_FIRST;
        res.x = AXIS_W'(cur_x);
        res.y = AXIS_W'(cur_y);
        res.btn = pkt_first[BTN_W-1:0];
        hit = 1'b1;
      end
      default: begin
        if (b[SYNC_BIT]) begin
          pkt_first = b;
          pkt_phase = PH_XDELTA;
        end else begin
          pkt_phase = PH_FIRST;
        end
      end
    endcase
  endfunction

  // sender gaps: mostly none or short, a few long, with gap-free bursts
  function automatic int unsigned next_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(30, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // deltas lean toward the signed extremes
  function automatic logic [BYTE_W-1:0] pick_delta();
    case ($urandom_range(0, 19))
      0: return 8'h7F;
      1: return 8'h80;
      2: return 8'h00;
      3: return 8'hFF;
      4: return 8'h01;
      default: return 8'($urandom);
    endcase
  endfunction

  // one byte transfer on the input channel
  task automatic send_byte(input logic aux, input logic [BYTE_W-1:0] b,
                           input logic typed, input cursor_t typed_res);
    logic hit;
    cursor_t res;
    int unsigned gap;
    in_valid <= 1'b1;
    in_aux_data <= aux;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    track_mouse_byte(aux, b, hit, res);
    if (hit) expected_cursor_q.push_back(typed ? typed_res : res);
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_cursor_q.size() != 0);
  endtask

  // register write once the pipeline has drained
  task automatic write_size_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [SIZE_W-1:0] val);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_size_write(idx, val);
  endtask

  // pad a half-sent packet so the next phase starts framed
  task automatic close_packet();
    while (pkt_phase != PH_FIRST) send_byte(1'b1, pick_delta(), 1'b0, '0);
  endtask

  // mostly whole packets, some keyboard noise, stray and cut-short packets
  task automatic run_mouse_traffic(input int unsigned n_bytes);
    int unsigned sent;
    int unsigned pick;
    logic [BYTE_W-1:0] pkt [3];
    sent = 0;
    while (sent < n_bytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_byte(1'b0, 8'($urandom), 1'b0, '0);
      end else if (pick < 13) begin
        send_byte(1'b1, 8'($urandom) & ~8'h08, 1'b0, '0);
        sent++;
      end else if (pick < 16) begin
        send_byte(1'b1, 8'($urandom) | 8'h08, 1'b0, '0);
        sent++;
      end else begin
        pkt[0] = 8'($urandom) | 8'h08;
        pkt[1] = pick_delta();
        pkt[2] = pick_delta();
        for (int k = 0; k < 3; k++) begin
          if ($urandom_range(0, 19) == 0) send_byte(1'b0, 8'($urandom), 1'b0, '0);
          send_byte(1'b1, pkt[k], 1'b0, '0);
        end
        sent += 3;
      end
      if ($urandom_range(0, 199) == 0) wait_for_results();
    end
    close_packet();
  endtask

  // output stall: idle stretches, short blips and a few long holds
  always @(posedge clk) begin
    if (calm_left > 0) begin
      calm_left--;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      case ($urandom_range(0, 19))
        0: calm_left = $urandom_range(20, 150);
        1: stall_left = $urandom_range(8, 40);
        2, 3, 4, 5: stall_left = $urandom_range(1, 3);
        default: ;
      endcase
      out_stall <= 1'b0;
    end
  end

  // result transfer check against the oldest expectation
  always @(posedge clk) begin
    cursor_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cursor_q.size() == 0) begin
        $error("unexpected result x=%0d y=%0d buttons=%0d",
               out_cursor_x, out_cursor_y, out_buttons);
        fail_count++;
      end else begin
        want = expected_cursor_q.pop_front();
        if (out_cursor_x !== want.x) begin
          $error("cursor_x expected %0d got %0d", want.x, out_cursor_x);
          fail_count++;
        end
        if (out_cursor_y !== want.y) begin
          $error("cursor_y expected %0d got %0d", want.y, out_cursor_y);
          fail_count++;
        end
        if (out_buttons !== want.btn) begin
          $error("buttons expected %0d got %0d", want.btn, out_buttons);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [SIZE_W-1:0] w_sz;
    logic [SIZE_W-1:0] h_sz;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        write_size_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        send_byte(dir_tab[i].aux, dir_tab[i].b, dir_tab[i].typed, dir_tab[i].want);
      end
    end
    close_packet();

    // random phases over several screen sizes
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: begin w_sz = 13'd640;  h_sz = 13'd480;  end
        1: begin w_sz = 13'd0;    h_sz = 13'd1;    end
        2: begin w_sz = 13'd1;    h_sz = 13'd8191; end
        3: begin w_sz = 13'd4096; h_sz = 13'd4096; end
        4: begin w_sz = 13'd8191; h_sz = 13'd0;    end
        5: begin w_sz = 13'd2;    h_sz = 13'd3;    end
        default: begin
          w_sz = SIZE_W'($urandom_range(1, 4096));
          h_sz = SIZE_W'($urandom_range(1, 4096));
        end
      endcase
      if ($urandom_range(0, 1) == 0) begin
        write_size_reg(REG_SCREEN_WIDTH, w_sz);
        write_size_reg(REG_SCREEN_HEIGHT, h_sz);
      end else begin
        write_size_reg(REG_SCREEN_HEIGHT, h_sz);
        write_size_reg(REG_SCREEN_WIDTH, w_sz);
      end
      if ($urandom_range(0, 2) == 0) begin
        write_size_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, 13'($urandom));
      end
      run_mouse_traffic(BYTES_PER_PHASE);
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
